>>> rtl/olrs_pkg.sv
// Shared definitions for the overwrite log ring with snapshot.
// Field widths, reset values and operation codes; no dependencies.
package olrs_pkg;

  localparam int unsigned BYTE_W = 8;
  localparam int unsigned CNT_W = 11;
  localparam int unsigned IDX_W = 10;
  localparam int unsigned OP_W = 3;

  localparam int unsigned RING_DEPTH_DEF = 1024;
  localparam logic [CNT_W-1:0] RING_SIZE_RST = 11'd1024;

  typedef enum logic [OP_W-1:0] {
    OP_APPEND     = 3'd0,
    OP_CAPTURE    = 3'd1,
    OP_READ_RING  = 3'd2,
    OP_READ_SNAP  = 3'd3,
    OP_CLEAR_RING = 3'd4,
    OP_CLEAR_SNAP = 3'd5
  } op_e;

endpackage

>>> rtl/olrs_ram.sv
// Simple dual-port byte memory: one write port, one read port, registered read data.
// Depends on olrs_pkg for the default depth and data width.
module olrs_ram
  import olrs_pkg::*;
#(
  parameter int unsigned DEPTH = RING_DEPTH_DEF,
  parameter int unsigned AW    = $clog2(DEPTH),
  parameter int unsigned W     = BYTE_W
) (
  input  logic          clk_i,
  input  logic          we_i,
  input  logic [AW-1:0] waddr_i,
  input  logic [W-1:0]  wdata_i,
  input  logic          re_i,
  input  logic [AW-1:0] raddr_i,
  output logic [W-1:0]  rdata_o
);

  logic [W-1:0] mem_q [DEPTH];
  logic [W-1:0] rdata_q;

  // Write one entry
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Read one entry, hold the data until the next read
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

>>> rtl/olrs_mod.sv
// Iterative remainder unit: one quotient bit per cycle.
// Depends on olrs_pkg for the count width.
module olrs_mod
  import olrs_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  input  logic [CNT_W-1:0] dividend_i,
  input  logic [CNT_W-1:0] divisor_i,
  output logic             done_o,
  output logic [CNT_W-1:0] rem_o
);

  localparam int unsigned CW = $clog2(CNT_W + 1);

  logic             busy_q, busy_d;
  logic             done_q, done_d;
  logic [CW-1:0]    cnt_q, cnt_d;
  logic [CNT_W-1:0] dvd_q, dvd_d;
  logic [CNT_W-1:0] dsr_q, dsr_d;
  logic [CNT_W-1:0] rem_q, rem_d;
  logic [CNT_W:0]   rem_sh;

  assign rem_sh = {rem_q, dvd_q[CNT_W-1]};

  // Shift in one dividend bit, subtract the divisor when it fits
  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    dvd_d  = dvd_q;
    dsr_d  = dsr_q;
    rem_d  = rem_q;
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = '0;
      dvd_d  = dividend_i;
      dsr_d  = divisor_i;
      rem_d  = '0;
    end else if (busy_q) begin
      if (rem_sh >= {1'b0, dsr_q}) begin
        rem_d = CNT_W'(rem_sh - {1'b0, dsr_q});
      end else begin
        rem_d = rem_sh[CNT_W-1:0];
      end
      dvd_d = {dvd_q[CNT_W-2:0], 1'b0};
      cnt_d = cnt_q + CW'(1);
      if (cnt_q == CW'(CNT_W - 1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    dvd_q <= dvd_d;
    dsr_q <= dsr_d;
    rem_q <= rem_d;
  end

  assign done_o = done_q;
  assign rem_o  = rem_q;

endmodule

>>> rtl/overwrite_log_ring_with_snapshot_top.sv
// Byte trace ring that overwrites its oldest data, with a linear snapshot copy.
// Uses olrs_pkg, olrs_ram (ring and snapshot stores) and olrs_mod (head wrap).
//
// Usage:
//   Input channel (in_valid_i / in_stall_o) carries one item: op_i, data_byte_i,
//   read_index_i. Output channel (out_valid_o / out_stall_i) returns one result
//   item per input item, in order. The cfg channel (cfg_valid_i / cfg_ready_o)
//   writes ring_size; write it only while no item is in flight.
//   Append, read and clear items are taken one per cycle while the input is not
//   stalled; each result passes from the read stage (memory data and read stage
//   load at the accepting edge) to the output register. The rate is set by
//   the single read port of each memory.
//   A capture copies one live byte per cycle through the ring read port and the
//   snapshot write port, and holds the input stalled until the copy is done.
//   A ring_size write recomputes the head position with a bit-serial remainder
//   unit; input is stalled until the recompute is done.
//   Reset empties the ring and drops the snapshot; ring_size returns to 1024.
//   Store contents are not cleared, so no clearing pass runs after reset.
//   When the receiver stalls, the result waits in the output register, one more
//   item may advance into the read stage, and then the input is stalled.
module overwrite_log_ring_with_snapshot_top
  import olrs_pkg::*;
#(
  parameter int unsigned RING_DEPTH = RING_DEPTH_DEF
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  // input items
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  logic [OP_W-1:0]   op_i,
  input  logic [BYTE_W-1:0] data_byte_i,
  input  logic [IDX_W-1:0]  read_index_i,
  // result items
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output logic [BYTE_W-1:0] read_byte_o,
  output logic              read_valid_o,
  output logic [CNT_W-1:0]  fill_level_o,
  output logic [CNT_W-1:0]  snap_length_o,
  output logic              snap_present_o,
  // ring_size register write
  input  logic              cfg_valid_i,
  output logic              cfg_ready_o,
  input  logic [CNT_W-1:0]  cfg_data_i
);

  localparam int unsigned AW = $clog2(RING_DEPTH);
  localparam int unsigned DW = $clog2(RING_DEPTH + 1);
  localparam int unsigned PW = (DW > CNT_W) ? DW : CNT_W;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_NORM,
    ST_OLDEST,
    ST_CAPT
  } state_e;

  state_e st_q, st_d;

  // ring state
  logic [CNT_W-1:0] ring_size_q, ring_size_d;
  logic [CNT_W-1:0] wp_q, wp_d;
  logic [CNT_W-1:0] hp_q, hp_d;
  logic [CNT_W-1:0] oldest_q, oldest_d;
  logic [CNT_W-1:0] fill_q, fill_d;
  logic [CNT_W-1:0] snap_cnt_q, snap_cnt_d;
  logic             snap_flag_q, snap_flag_d;
  logic             norm_start_q, norm_start_d;

  // capture sequencer
  logic [CNT_W-1:0] cp_n_q, cp_n_d;
  logic [CNT_W-1:0] cp_src_q, cp_src_d;
  logic [CNT_W-1:0] cp_cnt_q, cp_cnt_d;
  logic [CNT_W-1:0] cp_widx_q, cp_widx_d;
  logic             cp_pend_q, cp_pend_d;

  // read stage and output register
  logic             s1_valid_q, s1_valid_d;
  logic             s1_rd_ring_q, s1_rd_ring_d;
  logic             s1_rd_snap_q, s1_rd_snap_d;
  logic [CNT_W-1:0] s1_fill_q, s1_fill_d;
  logic [CNT_W-1:0] s1_slen_q, s1_slen_d;
  logic             s1_spres_q, s1_spres_d;
  logic             out_valid_q, out_valid_d;
  logic [BYTE_W-1:0] out_byte_q, out_byte_d;
  logic             out_rvalid_q, out_rvalid_d;
  logic [CNT_W-1:0] out_fill_q, out_fill_d;
  logic [CNT_W-1:0] out_slen_q, out_slen_d;
  logic             out_spres_q, out_spres_d;

  // derived values
  logic [PW-1:0]    rs_ext, eff_ext;
  logic [CNT_W-1:0] sz, live, idx_ext, hp_inc, hp_nxt, fill_app, rd_slot, src_inc;
  logic [CNT_W:0]   rd_sum;
  logic             s1_go, in_acc;

  // memory ports
  logic             ring_we, ring_re, snap_we, snap_re;
  logic [CNT_W-1:0] ring_raddr_n;
  logic [PW-1:0]    ring_waddr_ext, ring_raddr_ext, snap_waddr_ext, snap_raddr_ext;
  logic [BYTE_W-1:0] ring_rdata, snap_rdata;

  // remainder unit
  logic             mod_start, mod_done;
  logic [CNT_W-1:0] mod_rem;

  // Effective ring size and live byte count
  assign rs_ext  = PW'(ring_size_q);
  assign eff_ext = (rs_ext > PW'(RING_DEPTH)) ? PW'(RING_DEPTH) : rs_ext;
  assign sz      = eff_ext[CNT_W-1:0];
  assign live    = (fill_q < sz) ? fill_q : sz;
  assign idx_ext = CNT_W'(read_index_i);

  // Head advance with wrap, saturating fill count
  assign hp_inc   = hp_q + CNT_W'(1);
  assign hp_nxt   = (hp_inc == sz) ? '0 : hp_inc;
  assign fill_app = (fill_q < sz) ? fill_q + CNT_W'(1) : sz;

  // Physical slot of a ring read, counted from the oldest byte
  assign rd_sum  = {1'b0, oldest_q} + (CNT_W+1)'(read_index_i);
  assign rd_slot = (rd_sum >= {1'b0, sz}) ? CNT_W'(rd_sum - {1'b0, sz}) : rd_sum[CNT_W-1:0];
  assign src_inc = ((cp_src_q + CNT_W'(1)) == sz) ? '0 : cp_src_q + CNT_W'(1);

  // Handshakes
  assign s1_go       = s1_valid_q & (~out_valid_q | ~out_stall_i);
  assign in_stall_o  = (st_q != ST_IDLE) | cfg_valid_i | (s1_valid_q & ~s1_go);
  assign in_acc      = in_valid_i & ~in_stall_o;
  assign cfg_ready_o = (st_q == ST_IDLE);

  // Next state: item handling, head recompute, capture copy, output advance
  always_comb begin
    st_d         = st_q;
    ring_size_d  = ring_size_q;
    wp_d         = wp_q;
    hp_d         = hp_q;
    oldest_d     = oldest_q;
    fill_d       = fill_q;
    snap_cnt_d   = snap_cnt_q;
    snap_flag_d  = snap_flag_q;
    norm_start_d = 1'b0;
    cp_n_d       = cp_n_q;
    cp_src_d     = cp_src_q;
    cp_cnt_d     = cp_cnt_q;
    cp_widx_d    = cp_widx_q;
    cp_pend_d    = cp_pend_q;
    s1_valid_d   = s1_valid_q;
    s1_rd_ring_d = s1_rd_ring_q;
    s1_rd_snap_d = s1_rd_snap_q;
    s1_fill_d    = s1_fill_q;
    s1_slen_d    = s1_slen_q;
    s1_spres_d   = s1_spres_q;
    ring_we      = 1'b0;
    ring_re      = 1'b0;
    ring_raddr_n = rd_slot;
    snap_we      = 1'b0;
    snap_re      = 1'b0;
    mod_start    = 1'b0;

    if (s1_go) begin
      s1_valid_d = 1'b0;
    end

    case (st_q)
      ST_IDLE: begin
        if (cfg_valid_i) begin
          ring_size_d  = cfg_data_i;
          norm_start_d = 1'b1;
          st_d         = ST_NORM;
        end else if (in_acc) begin
          s1_valid_d   = 1'b1;
          s1_rd_ring_d = 1'b0;
          s1_rd_snap_d = 1'b0;
          s1_fill_d    = live;
          s1_slen_d    = snap_cnt_q;
          s1_spres_d   = snap_flag_q;
          case (op_e'(op_i))
            OP_APPEND: begin
              if (sz != '0) begin
                ring_we   = 1'b1;
                hp_d      = hp_nxt;
                wp_d      = hp_nxt;
                fill_d    = fill_app;
                s1_fill_d = fill_app;
                if (fill_q >= sz) begin
                  oldest_d = hp_nxt;
                end
              end
            end
            OP_CAPTURE: begin
              s1_valid_d = 1'b0;
              cp_n_d     = live;
              cp_src_d   = oldest_q;
              cp_cnt_d   = '0;
              cp_pend_d  = 1'b0;
              st_d       = ST_CAPT;
            end
            OP_READ_RING: begin
              ring_re      = 1'b1;
              s1_rd_ring_d = (idx_ext < live);
            end
            OP_READ_SNAP: begin
              snap_re      = 1'b1;
              s1_rd_snap_d = snap_flag_q & (idx_ext < snap_cnt_q);
            end
            OP_CLEAR_RING: begin
              wp_d      = '0;
              hp_d      = '0;
              oldest_d  = '0;
              fill_d    = '0;
              s1_fill_d = '0;
            end
            OP_CLEAR_SNAP: begin
              snap_cnt_d  = '0;
              snap_flag_d = 1'b0;
              s1_slen_d   = '0;
              s1_spres_d  = 1'b0;
            end
            default: ;
          endcase
        end
      end
      ST_NORM: begin
        mod_start = norm_start_q;
        if (mod_done) begin
          hp_d = mod_rem;
          st_d = ST_OLDEST;
        end
      end
      ST_OLDEST: begin
        if (hp_q >= live) begin
          oldest_d = hp_q - live;
        end else begin
          oldest_d = CNT_W'({1'b0, hp_q} + {1'b0, sz} - {1'b0, live});
        end
        st_d = ST_IDLE;
      end
      ST_CAPT: begin
        // write the byte read last cycle, issue the next ring read
        snap_we = cp_pend_q;
        if (cp_cnt_q < cp_n_q) begin
          ring_re      = 1'b1;
          ring_raddr_n = cp_src_q;
          cp_src_d     = src_inc;
          cp_cnt_d     = cp_cnt_q + CNT_W'(1);
          cp_widx_d    = cp_cnt_q;
          cp_pend_d    = 1'b1;
        end else begin
          cp_pend_d = 1'b0;
          if (!cp_pend_q) begin
            snap_cnt_d   = cp_n_q;
            snap_flag_d  = 1'b1;
            s1_valid_d   = 1'b1;
            s1_rd_ring_d = 1'b0;
            s1_rd_snap_d = 1'b0;
            s1_fill_d    = live;
            s1_slen_d    = cp_n_q;
            s1_spres_d   = 1'b1;
            st_d         = ST_IDLE;
          end
        end
      end
      default: begin
        st_d = ST_IDLE;
      end
    endcase
  end

  // Output register: load from the read stage, drop once taken
  always_comb begin
    out_valid_d  = out_valid_q;
    out_byte_d   = out_byte_q;
    out_rvalid_d = out_rvalid_q;
    out_fill_d   = out_fill_q;
    out_slen_d   = out_slen_q;
    out_spres_d  = out_spres_q;
    if (s1_go) begin
      out_valid_d  = 1'b1;
      out_rvalid_d = s1_rd_ring_q | s1_rd_snap_q;
      if (s1_rd_ring_q) begin
        out_byte_d = ring_rdata;
      end else if (s1_rd_snap_q) begin
        out_byte_d = snap_rdata;
      end else begin
        out_byte_d = '0;
      end
      out_fill_d  = s1_fill_q;
      out_slen_d  = s1_slen_q;
      out_spres_d = s1_spres_q;
    end else if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  // Control state and registered outputs
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q         <= ST_IDLE;
      ring_size_q  <= RING_SIZE_RST;
      wp_q         <= '0;
      hp_q         <= '0;
      oldest_q     <= '0;
      fill_q       <= '0;
      snap_cnt_q   <= '0;
      snap_flag_q  <= 1'b0;
      norm_start_q <= 1'b0;
      cp_cnt_q     <= '0;
      cp_pend_q    <= 1'b0;
      s1_valid_q   <= 1'b0;
      out_valid_q  <= 1'b0;
    end else begin
      st_q         <= st_d;
      ring_size_q  <= ring_size_d;
      wp_q         <= wp_d;
      hp_q         <= hp_d;
      oldest_q     <= oldest_d;
      fill_q       <= fill_d;
      snap_cnt_q   <= snap_cnt_d;
      snap_flag_q  <= snap_flag_d;
      norm_start_q <= norm_start_d;
      cp_cnt_q     <= cp_cnt_d;
      cp_pend_q    <= cp_pend_d;
      s1_valid_q   <= s1_valid_d;
      out_valid_q  <= out_valid_d;
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    cp_n_q       <= cp_n_d;
    cp_src_q     <= cp_src_d;
    cp_widx_q    <= cp_widx_d;
    s1_rd_ring_q <= s1_rd_ring_d;
    s1_rd_snap_q <= s1_rd_snap_d;
    s1_fill_q    <= s1_fill_d;
    s1_slen_q    <= s1_slen_d;
    s1_spres_q   <= s1_spres_d;
    out_byte_q   <= out_byte_d;
    out_rvalid_q <= out_rvalid_d;
    out_fill_q   <= out_fill_d;
    out_slen_q   <= out_slen_d;
    out_spres_q  <= out_spres_d;
  end

  assign out_valid_o    = out_valid_q;
  assign read_byte_o    = out_byte_q;
  assign read_valid_o   = out_rvalid_q;
  assign fill_level_o   = out_fill_q;
  assign snap_length_o  = out_slen_q;
  assign snap_present_o = out_spres_q;

  // Memory addresses
  assign ring_waddr_ext = PW'(hp_q);
  assign ring_raddr_ext = PW'(ring_raddr_n);
  assign snap_waddr_ext = PW'(cp_widx_q);
  assign snap_raddr_ext = PW'(read_index_i);

  olrs_ram #(
    .DEPTH (RING_DEPTH),
    .AW    (AW),
    .W     (BYTE_W)
  ) u_ring_ram (
    .clk_i   (clk_i),
    .we_i    (ring_we),
    .waddr_i (ring_waddr_ext[AW-1:0]),
    .wdata_i (data_byte_i),
    .re_i    (ring_re),
    .raddr_i (ring_raddr_ext[AW-1:0]),
    .rdata_o (ring_rdata)
  );

  olrs_ram #(
    .DEPTH (RING_DEPTH),
    .AW    (AW),
    .W     (BYTE_W)
  ) u_snap_ram (
    .clk_i   (clk_i),
    .we_i    (snap_we),
    .waddr_i (snap_waddr_ext[AW-1:0]),
    .wdata_i (ring_rdata),
    .re_i    (snap_re),
    .raddr_i (snap_raddr_ext[AW-1:0]),
    .rdata_o (snap_rdata)
  );

  olrs_mod u_mod (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (mod_start),
    .dividend_i (wp_q),
    .divisor_i  (sz),
    .done_o     (mod_done),
    .rem_o      (mod_rem)
  );

  // Head and oldest slot stay inside the ring while items are taken
  a_hp_in_ring: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (st_q == ST_IDLE && sz != '0) |-> (hp_q < sz))
    else $error("head position outside the ring");

  a_oldest_in_ring: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (st_q == ST_IDLE && sz != '0) |-> (oldest_q < sz))
    else $error("oldest slot outside the ring");

  // The copy uses the ring read port, so no read result may be waiting
  a_capt_stage_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (st_q == ST_CAPT) |-> !s1_valid_q)
    else $error("ring read pending during capture");

  a_capt_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (st_q == ST_CAPT && st_d == ST_IDLE) |=> (snap_flag_q && s1_valid_q))
    else $error("capture finished without snapshot flag or result");

endmodule
